@@ rtl/core/rgblab_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_pkg
// Shared types, widths, constants and the sRGB linearization table for the
// sRGB to CIE L*a*b* (D65) converter.
// ----------------------------------------------------------------------------
package rgblab_pkg;

    // Default output precision
    localparam int FRAC_BITS_DEF = 8;

    // Datapath widths
    localparam int COEF_W   = 24;            // matrix and white point constants
    localparam int LIN_W    = 17;            // linear channel, Q16, 0..65536
    localparam int PROD_W   = LIN_W + COEF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int NUM_W    = SUM_W + 8;     // ratio numerator, sum*256 + D/2
    localparam int RCP_W    = 28;            // 2^NUM_W / white point
    localparam int Q_W      = 25;            // Q24 ratio and companded value
    localparam int SQ_W     = 2 * Q_W - 24;  // square of a candidate root
    localparam int CUBE_W   = SQ_W + Q_W - 24;
    localparam int N2_W     = 32;            // linear segment numerator
    localparam int D2_STEPS = 22;            // quotient bits of linear segment
    localparam int LIN_SH   = 42;            // reciprocal scale of linear segment
    localparam int MIX_W    = 38;            // Q24 L/a/b before rounding

    // Pipeline depth of one companding lane, sum in to f out
    localparam int DIV_STAGES  = 5;
    localparam int CUBE_STAGES = 2 * Q_W;
    localparam int LANE_LAT    = 1 + DIV_STAGES + CUBE_STAGES;

    // Linear segment: (9033*v + 160*2^24 + 580) / 1160
    localparam logic [N2_W-1:0] LIN_MUL = N2_W'(9033);
    localparam logic [N2_W-1:0] LIN_OFS = N2_W'(64'd160 * 64'd16777216 + 64'd580);
    localparam logic [N2_W-1:0] LIN_DIV = N2_W'(1160);
    localparam logic [N2_W-1:0] LIN_RCP = N2_W'((64'd1 << LIN_SH) / 64'd1160);

    // v*1e6 > 8856*2^24 is the same as v > floor(8856*2^24/1e6)
    localparam logic [Q_W-1:0] CUBE_MIN = Q_W'((64'd8856 * 64'd16777216) / 64'd1000000);

    // sRGB to XYZ matrix in units of 1e-7
    localparam logic [COEF_W-1:0] MAT_COEF [3][3] = '{
        '{24'd4124564, 24'd3575761, 24'd1804375},
        '{24'd2126729, 24'd7151522, 24'd721750},
        '{24'd193339,  24'd1191920, 24'd9503041}
    };

    // D65 reference white in units of 1e-7
    localparam logic [COEF_W-1:0] WHITE_DIV [3] = '{
        24'd9504560, 24'd10000000, 24'd10887540
    };

    // Payload of one pixel transaction
    typedef struct packed {
        logic [23:0] pixel_rgb;
        logic        last_pixel;
    } pixel_t;

    // Payload of one L*a*b* transaction
    typedef struct packed {
        logic [14:0]        lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
        logic               end_of_image;
    } lab_t;

    typedef logic [LIN_W-1:0] lin_t;
    typedef lin_t lin_table_t [256];

    // sRGB curve in Q16, evaluated at elaboration
    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        longint     t;
        longint     t2;
        longint     r;
        longint     cand;
        longint     p2;
        longint     p4;
        longint     p5;
        longint     val;
        for (int c = 0; c < 256; c++)
        begin
            if (c <= 10)
            begin
                val = (longint'(c) * 64'd6553600 + 64'd164730) / 64'd329460;
            end
            else
            begin
                t  = ((longint'(c) * 64'd1000 + 64'd14025) * 64'd16777216 + 64'd134512)
                     / 64'd269025;
                t2 = (t * t + 64'd8388608) >>> 24;
                r  = 0;
                // fifth root of t^2, one bit a step
                for (int b = 24; b >= 0; b--)
                begin
                    cand = r | (64'd1 << b);
                    p2   = (cand * cand) >>> 24;
                    p4   = (p2 * p2) >>> 24;
                    p5   = (p4 * cand) >>> 24;
                    if (p5 <= t2)
                    begin
                        r = cand;
                    end
                end
                val = (t2 * r + 64'd2147483648) >>> 32;
            end
            tbl[c] = LIN_W'(val);
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

@@ rtl/core/rgblab_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface rgblab_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/rgblab_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_lane
// One XYZ component: divide by the white point to a Q24 ratio, then apply
// the CIE companding function (cube root or linear segment). Fixed latency.
// ----------------------------------------------------------------------------
module rgblab_lane #(
    parameter logic [rgblab_pkg::COEF_W-1:0] DIVISOR = rgblab_pkg::WHITE_DIV[1]
) (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [rgblab_pkg::SUM_W-1:0] sum,
    output logic [rgblab_pkg::Q_W-1:0]   f
);
    import rgblab_pkg::*;

    localparam int EP_W = NUM_W - 16 + RCP_W;
    localparam int BP_W = Q_W + COEF_W;
    localparam logic [NUM_W-1:0] HALF_DIV = NUM_W'(DIVISOR / 2);
    localparam logic [NUM_W-1:0] DIV_1X   = NUM_W'(DIVISOR);
    localparam logic [NUM_W-1:0] DIV_2X   = NUM_W'(DIVISOR) << 1;
    localparam logic [RCP_W-1:0] RECIP    = RCP_W'((64'd1 << NUM_W) / 64'(DIVISOR));

    // Ratio division by reciprocal, then remainder correction
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_d1_reg;
    logic [NUM_W-1:0] num_d2_reg;
    logic [Q_W-1:0]   est_reg;
    logic [Q_W-1:0]   est_d2_reg;
    logic [Q_W-1:0]   est_d3_reg;
    logic [BP_W-1:0]  back_reg;
    logic [NUM_W-1:0] dif_reg;
    logic [Q_W-1:0]   ratio_reg;
    logic [EP_W-1:0]  est_full;
    logic [BP_W-1:0]  back_full;
    logic [Q_W-1:0]   fix;

    // Companding stages
    logic [Q_W-1:0]   cv_reg  [CUBE_STAGES];
    logic             big_reg [CUBE_STAGES+1];
    logic [Q_W-1:0]   r_reg   [CUBE_STAGES+1];
    logic [SQ_W-1:0]  sq_reg  [Q_W];

    // Linear segment
    logic [N2_W-1:0]     n2;
    logic [N2_W-1:0]     n2_reg;
    logic [N2_W-1:0]     n2_d1_reg;
    logic [N2_W-1:0]     n2_d2_reg;
    logic [63:0]         l2_full;
    logic [D2_STEPS-1:0] q2e_reg;
    logic [D2_STEPS-1:0] q2e_d_reg;
    logic [N2_W-1:0]     back2_reg;
    logic [D2_STEPS-1:0] q2_reg [CUBE_STAGES-2];

    // Estimate never exceeds the quotient and is short by at most two
    assign est_full  = EP_W'(num_reg[NUM_W-1:16]) * EP_W'(RECIP);
    assign back_full = BP_W'(est_reg) * BP_W'(DIVISOR);

    always_comb
    begin
        if (dif_reg >= DIV_2X)
        begin
            fix = Q_W'(2);
        end
        else if (dif_reg >= DIV_1X)
        begin
            fix = Q_W'(1);
        end
        else
        begin
            fix = '0;
        end
    end

    // Numerator, estimate, back product, remainder, corrected ratio
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg    <= {sum, 8'd0} + HALF_DIV;
            est_reg    <= est_full[NUM_W-16 +: Q_W];
            num_d1_reg <= num_reg;
            back_reg   <= back_full;
            est_d2_reg <= est_reg;
            num_d2_reg <= num_d1_reg;
            dif_reg    <= num_d2_reg - NUM_W'(back_reg);
            est_d3_reg <= est_d2_reg;
            ratio_reg  <= est_d3_reg + fix;
        end
    end

    // Branch select and linear segment numerator
    assign n2 = N2_W'(ratio_reg) * LIN_MUL + LIN_OFS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cv_reg[0]  <= ratio_reg;
            big_reg[0] <= (ratio_reg > CUBE_MIN);
            n2_reg     <= n2;
            r_reg[0]   <= '0;
        end
    end

    // Linear segment divide by 1160: reciprocal estimate, one correction,
    // then delayed to line up with the cube root
    assign l2_full = 64'(n2_reg) * 64'(LIN_RCP);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q2e_reg   <= l2_full[LIN_SH +: D2_STEPS];
            n2_d1_reg <= n2_reg;
            back2_reg <= N2_W'(q2e_reg) * LIN_DIV;
            q2e_d_reg <= q2e_reg;
            n2_d2_reg <= n2_d1_reg;
            q2_reg[0] <= q2e_d_reg + D2_STEPS'((n2_d2_reg - back2_reg) >= LIN_DIV);
            for (int j = 1; j < CUBE_STAGES - 2; j++)
            begin
                q2_reg[j] <= q2_reg[j-1];
            end
        end
    end

    // Cube root search (square, then cube and compare)
    for (genvar s = 1; s <= CUBE_STAGES; s++)
    begin : g_cube
        localparam int J    = (s - 1) / 2;
        localparam int PH   = (s - 1) % 2;
        localparam int BITP = Q_W - 1 - J;

        logic [Q_W-1:0] cand;
        assign cand = r_reg[s-1] | (Q_W'(1) << BITP);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                big_reg[s] <= big_reg[s-1];
            end
        end

        if (s < CUBE_STAGES)
        begin : g_cv
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cv_reg[s] <= cv_reg[s-1];
                end
            end
        end

        if (PH == 0)
        begin : g_sq
            logic [2*Q_W-1:0] sq_full;
            assign sq_full = {{Q_W{1'b0}}, cand} * {{Q_W{1'b0}}, cand};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_reg[J] <= sq_full[2*Q_W-1:24];
                    r_reg[s]  <= r_reg[s-1];
                end
            end
        end
        else
        begin : g_cb
            logic [SQ_W+Q_W-1:0] cube_full;
            logic [CUBE_W-1:0]   cube;
            assign cube_full = {{Q_W{1'b0}}, sq_reg[J]} * {{SQ_W{1'b0}}, cand};
            assign cube      = cube_full[SQ_W+Q_W-1:24];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    r_reg[s] <= (cube <= CUBE_W'(cv_reg[s-1])) ? cand : r_reg[s-1];
                end
            end
        end
    end

    assign f = big_reg[CUBE_STAGES] ? r_reg[CUBE_STAGES]
                                    : Q_W'(q2_reg[CUBE_STAGES-3]);

endmodule

@@ rtl/core/rgb_to_cielab_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cielab_converter
// sRGB pixel to CIE L*a*b* (D65), fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel    Dir   Payload                                      Handshake
//  pixel_in   in    pixel_rgb[23:0], last_pixel                  valid/ready
//  lab_out    out   lightness, green_red, blue_yellow,           valid/ready
//                   end_of_image
//
//  One pixel per clock while lab_out is not stalled; the stages from accepting edge to lab_out.valid
//  are table, matrix, 5 stage reciprocal divide, 50 cube root steps, mix, round.
//  Reset clears the valid bits only; no clearing pass.
//  A held result freezes the whole pipeline; pixel_in.ready drops only then.
// ----------------------------------------------------------------------------
module rgb_to_cielab_converter #(
    parameter int FRAC_BITS = rgblab_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rgblab_stream_if.sink          pixel_in,
    rgblab_stream_if.source        lab_out
);
    import rgblab_pkg::*;

    localparam int POS_LANE_END = 2 + LANE_LAT;
    localparam int POS_MIX      = POS_LANE_END + 1;
    localparam int POS_OUT      = POS_MIX + 1;
    localparam int SH           = 24 - FRAC_BITS;
    localparam logic [MIX_W-1:0] HALF = MIX_W'(1) << (SH - 1);
    localparam int LMAX_I = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
    localparam logic signed [MIX_W-1:0] LMAX  = MIX_W'(LMAX_I);
    localparam logic signed [MIX_W-1:0] L_OFS = MIX_W'(64'd16 << 24);
    localparam logic signed [MIX_W-1:0] K116  = MIX_W'(116);
    localparam logic signed [MIX_W-1:0] K500  = MIX_W'(500);
    localparam logic signed [MIX_W-1:0] K200  = MIX_W'(200);
    localparam logic signed [MIX_W-1:0] CMAX  = MIX_W'(32767);
    localparam logic signed [MIX_W-1:0] CMIN  = -MIX_W'(32768);

    logic adv;

    logic              vld_reg  [POS_OUT+1];
    logic              last_reg [POS_OUT+1];
    logic [LIN_W-1:0]  lin_reg  [3];
    logic [PROD_W-1:0] prod_reg [3][3];
    logic [SUM_W-1:0]  sum_reg  [3];
    logic [Q_W-1:0]    f_val    [3];
    logic signed [MIX_W-1:0] l_raw_reg;
    logic signed [MIX_W-1:0] a_raw_reg;
    logic signed [MIX_W-1:0] b_raw_reg;
    logic [14:0]       l_out_reg;
    logic [15:0]       a_out_reg;
    logic [15:0]       b_out_reg;

    // Round Q24 to FRAC_BITS, half away from zero
    function automatic logic signed [MIX_W-1:0] round_q(input logic signed [MIX_W-1:0] v);
        logic [MIX_W-1:0] mag;
        logic [MIX_W-1:0] rq;
        mag = v[MIX_W-1] ? MIX_W'(-v) : MIX_W'(v);
        rq  = (mag + HALF) >> SH;
        return v[MIX_W-1] ? -$signed(rq) : $signed(rq);
    endfunction

    function automatic logic signed [MIX_W-1:0] clamp(input logic signed [MIX_W-1:0] v,
                                                       input logic signed [MIX_W-1:0] lo,
                                                       input logic signed [MIX_W-1:0] hi);
        logic signed [MIX_W-1:0] res;
        res = v;
        if (v < lo)
        begin
            res = lo;
        end
        else if (v > hi)
        begin
            res = hi;
        end
        return res;
    endfunction

    // Global advance: move whenever the output slot is free or being taken
    assign adv            = !vld_reg[POS_OUT] || lab_out.ready;
    assign pixel_in.ready = adv;

    // Valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p <= POS_OUT; p++)
            begin
                vld_reg[p] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= pixel_in.valid;
            for (int p = 1; p <= POS_OUT; p++)
            begin
                vld_reg[p] <= vld_reg[p-1];
            end
        end
    end

    // Last flag line
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg[0] <= pixel_in.payload.last_pixel;
            for (int p = 1; p <= POS_OUT; p++)
            begin
                last_reg[p] <= last_reg[p-1];
            end
        end
    end

    // Linearize, matrix products, row sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lin_reg[0] <= LIN_TABLE[pixel_in.payload.pixel_rgb[23:16]];
            lin_reg[1] <= LIN_TABLE[pixel_in.payload.pixel_rgb[15:8]];
            lin_reg[2] <= LIN_TABLE[pixel_in.payload.pixel_rgb[7:0]];
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[i][k] <= PROD_W'(lin_reg[k]) * PROD_W'(MAT_COEF[i][k]);
                end
                sum_reg[i] <= SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                            + SUM_W'(prod_reg[i][2]);
            end
        end
    end

    // Per component white scaling and companding
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        rgblab_lane #(
            .DIVISOR (WHITE_DIV[i])
        ) u_lane (
            .clk (clk),
            .adv (adv),
            .sum (sum_reg[i]),
            .f   (f_val[i])
        );
    end

    // Form L, a, b in Q24
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_raw_reg <= K116 * $signed(MIX_W'(f_val[1])) - L_OFS;
            a_raw_reg <= K500 * ($signed(MIX_W'(f_val[0])) - $signed(MIX_W'(f_val[1])));
            b_raw_reg <= K200 * ($signed(MIX_W'(f_val[1])) - $signed(MIX_W'(f_val[2])));
        end
    end

    // Round and saturate into the output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_out_reg <= 15'(clamp(round_q(l_raw_reg), '0, LMAX));
            a_out_reg <= 16'(clamp(round_q(a_raw_reg), CMIN, CMAX));
            b_out_reg <= 16'(clamp(round_q(b_raw_reg), CMIN, CMAX));
        end
    end

    assign lab_out.valid                = vld_reg[POS_OUT];
    assign lab_out.payload.lightness    = l_out_reg;
    assign lab_out.payload.green_red    = $signed(a_out_reg);
    assign lab_out.payload.blue_yellow  = $signed(b_out_reg);
    assign lab_out.payload.end_of_image = last_reg[POS_OUT];

endmodule

@@ rtl/core/rgblab_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_checker
// Port level checks for the converter, attached by bind.
// ----------------------------------------------------------------------------
module rgblab_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input rgblab_pkg::lab_t   out_data
);
    import rgblab_pkg::*;

    // Held result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("lab_out.valid dropped while stalled");

    // Held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("lab_out payload changed while stalled");

    // A stalled output stops intake
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("pixel_in ready while output is stalled");

    // Intake only stops behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("pixel_in not ready with no result waiting");

endmodule

bind rgb_to_cielab_converter rgblab_checker u_rgblab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixel_in.ready),
    .out_valid (lab_out.valid),
    .out_ready (lab_out.ready),
    .out_data  (lab_out.payload)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sRGB to CIE L*a*b* converter. Random and corner pixels stream
// in with random gaps while the result side stalls at random. Each output
// transaction is compared with an integer L*a*b* calculation done in this
// file.
// ----------------------------------------------------------------------------
module tb_top;
    import rgblab_pkg::*;

    localparam int FRAC_BITS  = 8;
    localparam int PIPE_LAT   = 60;
    localparam int N_RANDOM   = 1525;
    localparam int CYCLE_MAX  = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rgblab_stream_if #(.payload_t(pixel_t)) pixel_ch ();
    rgblab_stream_if #(.payload_t(lab_t))   lab_ch ();

    rgb_to_cielab_converter #(.FRAC_BITS(FRAC_BITS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_ch.sink),
        .lab_out  (lab_ch.source)
    );

    always #2 clk = ~clk;

    pixel_t pixel_queue [$];
    lab_t   lab_expected [$];
    int     mismatch_cnt = 0;
    int     cycle_cnt = 0;
    bit     stim_done = 1'b0;
    bit     calm_mode = 1'b0;
    int     hold_off = 0;

    // sRGB curve to linear Q16
    function automatic longint srgb_to_linear(longint c);
        longint t;
        longint t2;
        longint r;
        longint cand;
        longint p;
        if (c <= 10)
            return (c * 6553600 + 164730) / 329460;
        t  = ((c * 1000 + 14025) * 64'd16777216 + 134512) / 269025;
        t2 = (t * t + 64'd8388608) >>> 24;
        r  = 0;
        for (int b = 24; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            p = (cand * cand) >>> 24;
            p = (p * p) >>> 24;
            p = (p * cand) >>> 24;
            if (p <= t2)
                r = cand;
        end
        return (t2 * r + 64'd2147483648) >>> 32;
    endfunction

    // CIE companding of a Q24 ratio
    function automatic longint lab_compand(longint v);
        longint r;
        longint cand;
        longint p;
        if (v * 1000000 > (64'd8856 << 24))
        begin
            r = 0;
            for (int b = 24; b >= 0; b--)
            begin
                cand = r | (64'd1 << b);
                p = (((cand * cand) >>> 24) * cand) >>> 24;
                if (p <= v)
                    r = cand;
            end
            return r;
        end
        return (9033 * v + (64'd160 << 24) + 580) / 1160;
    endfunction

    // Q24 to FRAC_BITS, round half away from zero
    function automatic longint round_frac(longint v);
        longint half;
        half = 64'd1 << (23 - FRAC_BITS);
        if (v >= 0)
            return (v + half) >>> (24 - FRAC_BITS);
        return -((-v + half) >>> (24 - FRAC_BITS));
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic lab_t predict_lab(pixel_t px);
        longint lin [3];
        longint fv [3];
        longint coef [3][3];
        longint wdiv [3];
        longint sum;
        longint lq;
        longint aq;
        longint bq;
        longint lmax;
        lab_t   res;
        coef = '{'{4124564, 3575761, 1804375}, '{2126729, 7151522, 721750},
                 '{193339, 1191920, 9503041}};
        wdiv = '{9504560, 10000000, 10887540};
        lin[0] = srgb_to_linear(longint'(px.pixel_rgb[23:16]));
        lin[1] = srgb_to_linear(longint'(px.pixel_rgb[15:8]));
        lin[2] = srgb_to_linear(longint'(px.pixel_rgb[7:0]));
        for (int i = 0; i < 3; i++)
        begin
            sum = 0;
            for (int k = 0; k < 3; k++)
                sum += lin[k] * coef[i][k];
            fv[i] = lab_compand((sum * 256 + wdiv[i] / 2) / wdiv[i]);
        end
        lq = round_frac(116 * fv[1] - (64'd16 << 24));
        aq = round_frac(500 * (fv[0] - fv[1]));
        bq = round_frac(200 * (fv[1] - fv[2]));
        lmax = clip(64'd100 << FRAC_BITS, 0, 32767);
        res.lightness    = 15'(clip(lq, 0, lmax));
        res.green_red    = 16'(clip(aq, -32768, 32767));
        res.blue_yellow  = 16'(clip(bq, -32768, 32767));
        res.end_of_image = px.last_pixel;
        return res;
    endfunction

    function automatic pixel_t make_pixel(logic [23:0] rgb, logic last);
        pixel_t px;
        px.pixel_rgb  = rgb;
        px.last_pixel = last;
        return px;
    endfunction

    // Append one pixel to the pending queue
    task automatic queue_pixel(logic [23:0] rgb, logic last);
        pixel_queue.insert(pixel_queue.size(), make_pixel(rgb, last));
    endtask

    // Stimulus
    initial
    begin
        logic [7:0] corner [6];
        corner = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
        // pure and mixed extremes, the curve segment boundary
        for (int i = 0; i < 6; i++)
            queue_pixel({3{corner[i]}}, i[0]);
        queue_pixel(24'hFF0000, 1'b0);
        queue_pixel(24'h00FF00, 1'b1);
        queue_pixel(24'h0000FF, 1'b0);
        queue_pixel(24'hFFFF00, 1'b0);
        queue_pixel(24'hFF00FF, 1'b1);
        queue_pixel(24'h00FFFF, 1'b0);
        queue_pixel(24'h0A0B0A, 1'b0);
        queue_pixel(24'h010000, 1'b0);
        queue_pixel(24'h000001, 1'b1);
        queue_pixel(24'hAAAAAA, 1'b0);
        queue_pixel(24'h555555, 1'b1);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_pixel({3{8'($urandom_range(0, 12))}} ^
                    24'($urandom_range(0, 7)), 1'($urandom));
            else
                queue_pixel(24'($urandom), 1'($urandom_range(0, 19) == 0));
        end
        stim_done = 1'b1;
    end

    // Reset
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: pixel transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_ch.valid   <= 1'b0;
            pixel_ch.payload <= '0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                lab_expected.insert(lab_expected.size(), predict_lab(pixel_ch.payload));
                void'(pixel_queue.pop_front());
            end
            if ((!pixel_ch.valid || pixel_ch.ready) && pixel_queue.size() > 0 &&
                (calm_mode || $urandom_range(0, 99) >= 22))
            begin
                // the head may already be the one just accepted; pick next
                if (pixel_ch.valid && pixel_ch.ready)
                begin
                    if (pixel_queue.size() > 0)
                    begin
                        pixel_ch.valid   <= 1'b1;
                        pixel_ch.payload <= pixel_queue[0];
                    end
                    else
                        pixel_ch.valid <= 1'b0;
                end
                else
                begin
                    pixel_ch.valid   <= 1'b1;
                    pixel_ch.payload <= pixel_queue[0];
                end
            end
            else if (pixel_ch.valid && pixel_ch.ready)
                pixel_ch.valid <= 1'b0;
        end
    end

    // Monitor and result stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lab_ch.ready <= 1'b0;
        else
        begin
            if (lab_ch.valid && lab_ch.ready)
            begin
                if (lab_expected.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected L*a*b* transaction %p", lab_ch.payload);
                end
                else
                begin
                    if (lab_ch.payload !== lab_expected[0])
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("L*a*b* mismatch: expected %p, got %p",
                                     lab_expected[0], lab_ch.payload);
                    end
                    void'(lab_expected.pop_front());
                end
            end
            if (hold_off > 0)
                lab_ch.ready <= 1'b0;
            else
                lab_ch.ready <= calm_mode || $urandom_range(0, 99) >= 22;
        end
    end

    // Long result hold-off and a stretch with no idling
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == 1500)
            hold_off <= 300;
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
        calm_mode <= (cycle_cnt >= 600 && cycle_cnt < 1100);
        if (cycle_cnt >= CYCLE_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // End of run
    initial
    begin
        wait (stim_done && rst_n);
        wait (pixel_queue.size() == 0 && lab_expected.size() == 0);
        repeat (PIPE_LAT + 20) @(posedge clk);
        if (mismatch_cnt == 0 && lab_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
